// ----- rtl/core/sict_pkg.sv -----
// Shared types and codes for the SIP client INVITE transaction block.
`default_nettype none

package sict_pkg;

    // Input item kinds
    localparam logic [2:0] KIND_START       = 3'd0;
    localparam logic [2:0] KIND_PROVISIONAL = 3'd1;
    localparam logic [2:0] KIND_FINAL       = 3'd2;
    localparam logic [2:0] KIND_TICK        = 3'd3;
    localparam logic [2:0] KIND_ABORT       = 3'd4;

    // Result actions
    localparam logic [2:0] ACT_SEND_REQ   = 3'd0;
    localparam logic [2:0] ACT_SEND_ACK   = 3'd1;
    localparam logic [2:0] ACT_RESEND_ACK = 3'd2;
    localparam logic [2:0] ACT_PROV       = 3'd3;
    localparam logic [2:0] ACT_FINAL      = 3'd4;
    localparam logic [2:0] ACT_TIMEOUT    = 3'd5;
    localparam logic [2:0] ACT_ABORTED    = 3'd6;

    // Status codes
    localparam logic [9:0] STATUS_UNAUTHORIZED    = 10'd401;
    localparam logic [9:0] STATUS_PROXY_AUTH      = 10'd407;
    localparam logic [9:0] STATUS_REQUEST_TIMEOUT = 10'd408;
    localparam logic [9:0] R_SUCCESS_LOW          = 10'd200;
    localparam logic [9:0] R_SUCCESS_HIGH         = 10'd299;

    // Configuration register indexes
    localparam logic [1:0] CFG_RETRANSMIT_BASE = 2'd0;
    localparam logic [1:0] CFG_OVERALL_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_COMPLETED_WAIT  = 2'd2;

    localparam int CFG_BITS = 24;

    typedef struct packed {
        logic [2:0] action;
        logic       copy_credentials;
        logic [9:0] reported_code;
    } sict_result_t;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0]   count;
        sict_result_t first;
        sict_result_t second;
    } sict_pair_t;

endpackage

`default_nettype wire

// ----- rtl/core/sict_txn.sv -----
// Transaction state, timers A, B and D, and result generation for one request.
`default_nettype none

module sict_txn #(
    parameter int TIMER_BITS = 24
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           fire,
    input  wire logic [2:0]                     kind,
    input  wire logic [9:0]                     status_code,
    input  wire logic [sict_pkg::CFG_BITS-1:0]  retransmit_base_ticks,
    input  wire logic [sict_pkg::CFG_BITS-1:0]  overall_timeout_ticks,
    input  wire logic [sict_pkg::CFG_BITS-1:0]  completed_wait_ticks,
    output sict_pkg::sict_pair_t                results
);

    localparam int CW = (TIMER_BITS > sict_pkg::CFG_BITS) ? TIMER_BITS : sict_pkg::CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;
    localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

    typedef enum logic [2:0] {
        PH_NULL,
        PH_CALLING,
        PH_PROCEEDING,
        PH_COMPLETED,
        PH_TERMINATED
    } phase_t;

    // Map a register value onto a timer load: zero becomes one, wide values saturate
    function automatic logic [TIMER_BITS-1:0] load_ticks(input logic [sict_pkg::CFG_BITS-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (v == '0) begin
            return TONE;
        end else if (ext > CW'(TMAX)) begin
            return TMAX;
        end
        return ext[TIMER_BITS-1:0];
    endfunction

    phase_t                phase_reg, phase_next;
    logic [TIMER_BITS-1:0] rt_left_reg, rt_left_next;
    logic [TIMER_BITS-1:0] rt_int_reg, rt_int_next;
    logic [TIMER_BITS-1:0] ov_left_reg, ov_left_next;
    logic [TIMER_BITS-1:0] cp_left_reg, cp_left_next;
    logic                  cred_reg, cred_next;

    logic [TIMER_BITS-1:0] base_load;
    logic [TIMER_BITS-1:0] rt_int_dbl;
    logic [TIMER_BITS-1:0] rt_rearm;
    logic                  success;
    logic                  copy_cred;
    logic                  a_fire;
    logic                  b_fire;

    assign base_load  = load_ticks(retransmit_base_ticks);
    // Double the interval, saturating at the counter width
    assign rt_int_dbl = rt_int_reg[TIMER_BITS-1] ? TMAX : {rt_int_reg[TIMER_BITS-2:0], 1'b0};
    assign rt_rearm   = (rt_int_reg == '0) ? TONE : rt_int_reg;
    assign success    = (status_code >= sict_pkg::R_SUCCESS_LOW) &&
                        (status_code <= sict_pkg::R_SUCCESS_HIGH);
    assign copy_cred  = (status_code != sict_pkg::STATUS_UNAUTHORIZED) &&
                        (status_code != sict_pkg::STATUS_PROXY_AUTH);
    assign a_fire     = (rt_left_reg == TONE);
    assign b_fire     = (ov_left_reg == TONE);

    always_comb begin
        phase_next   = phase_reg;
        rt_left_next = rt_left_reg;
        rt_int_next  = rt_int_reg;
        ov_left_next = ov_left_reg;
        cp_left_next = cp_left_reg;
        cred_next    = cred_reg;
        results      = '0;

        if (fire) begin
            case (kind)
                sict_pkg::KIND_START: begin
                    if (phase_reg == PH_NULL || phase_reg == PH_TERMINATED) begin
                        rt_left_next = base_load;
                        rt_int_next  = base_load[TIMER_BITS-1] ? TMAX :
                                       {base_load[TIMER_BITS-2:0], 1'b0};
                        ov_left_next = load_ticks(overall_timeout_ticks);
                        cp_left_next = '0;
                        cred_next    = 1'b0;
                        phase_next   = PH_CALLING;
                        results.count        = 2'd1;
                        results.first.action = sict_pkg::ACT_SEND_REQ;
                    end
                end
                sict_pkg::KIND_PROVISIONAL: begin
                    if (phase_reg == PH_CALLING || phase_reg == PH_PROCEEDING) begin
                        rt_left_next = '0;
                        ov_left_next = '0;
                        phase_next   = PH_PROCEEDING;
                        results.count               = 2'd1;
                        results.first.action        = sict_pkg::ACT_PROV;
                        results.first.reported_code = status_code;
                    end
                end
                sict_pkg::KIND_FINAL: begin
                    if (phase_reg == PH_CALLING || phase_reg == PH_PROCEEDING) begin
                        rt_left_next = '0;
                        ov_left_next = '0;
                        if (success) begin
                            phase_next = PH_TERMINATED;
                            results.count               = 2'd1;
                            results.first.action        = sict_pkg::ACT_FINAL;
                            results.first.reported_code = status_code;
                        end else begin
                            // Failure: ACK first, then report the final response
                            cred_next    = copy_cred;
                            cp_left_next = load_ticks(completed_wait_ticks);
                            phase_next   = PH_COMPLETED;
                            results.count                   = 2'd2;
                            results.first.action            = sict_pkg::ACT_SEND_ACK;
                            results.first.copy_credentials  = copy_cred;
                            results.first.reported_code     = status_code;
                            results.second.action           = sict_pkg::ACT_FINAL;
                            results.second.reported_code    = status_code;
                        end
                    end else if (phase_reg == PH_COMPLETED && !success) begin
                        results.count                  = 2'd1;
                        results.first.action           = sict_pkg::ACT_RESEND_ACK;
                        results.first.copy_credentials = cred_reg;
                        results.first.reported_code    = status_code;
                    end
                end
                sict_pkg::KIND_TICK: begin
                    if (phase_reg == PH_CALLING) begin
                        if (rt_left_reg != '0) begin
                            rt_left_next = rt_left_reg - TONE;
                        end
                        if (ov_left_reg != '0) begin
                            ov_left_next = ov_left_reg - TONE;
                        end
                        // Timer B takes priority over timer A on the same tick
                        if (b_fire) begin
                            rt_left_next = '0;
                            phase_next   = PH_TERMINATED;
                            results.count               = 2'd1;
                            results.first.action        = sict_pkg::ACT_TIMEOUT;
                            results.first.reported_code = sict_pkg::STATUS_REQUEST_TIMEOUT;
                        end else if (a_fire) begin
                            rt_left_next = rt_rearm;
                            rt_int_next  = rt_int_dbl;
                            results.count        = 2'd1;
                            results.first.action = sict_pkg::ACT_SEND_REQ;
                        end
                    end else if (phase_reg == PH_COMPLETED) begin
                        if (cp_left_reg != '0) begin
                            cp_left_next = cp_left_reg - TONE;
                            if (cp_left_reg == TONE) begin
                                phase_next = PH_TERMINATED;
                            end
                        end
                    end
                end
                sict_pkg::KIND_ABORT: begin
                    if (phase_reg == PH_PROCEEDING) begin
                        phase_next = PH_TERMINATED;
                        results.count               = 2'd1;
                        results.first.action        = sict_pkg::ACT_ABORTED;
                        results.first.reported_code = sict_pkg::STATUS_REQUEST_TIMEOUT;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_NULL;
            rt_left_reg <= '0;
            rt_int_reg  <= '0;
            ov_left_reg <= '0;
            cp_left_reg <= '0;
            cred_reg    <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            rt_left_reg <= rt_left_next;
            rt_int_reg  <= rt_int_next;
            ov_left_reg <= ov_left_next;
            cp_left_reg <= cp_left_next;
            cred_reg    <= cred_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/sict_out_buf.sv -----
// Two-entry result register that presents the results of one request in order.
`default_nettype none

module sict_out_buf (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  load,
    input  wire sict_pkg::sict_pair_t  pair,
    output logic                       space,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,
    output logic [2:0]                 m_tuser,
    output logic                       m_tlast
);

    logic [1:0]             cnt_reg, cnt_next;
    sict_pkg::sict_result_t slot0_reg, slot0_next;
    sict_pkg::sict_result_t slot1_reg, slot1_next;
    logic                   pop;

    assign pop      = m_tvalid && m_tready;
    // Room for a whole pair once the buffer drains this cycle
    assign space    = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tuser  = slot0_reg.action;
    assign m_tdata  = {5'd0, slot0_reg.reported_code, slot0_reg.copy_credentials};
    assign m_tlast  = (cnt_reg == 2'd1);

    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load) begin
            cnt_next   = pair.count;
            slot0_next = pair.first;
            slot1_next = pair.second;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/sip_client_invite_transaction.sv -----
// Top level of the SIP client INVITE transaction block.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  s_tuser kind, s_tdata status_code
//  m_       out        m_tvalid/m_tready  m_tuser action, m_tdata credentials+code, m_tlast
//  cfg_     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A request waits in the input register until the result register has room, then its results
// enter the result register, which presents them in order on the result channel.
// One request per cycle while each gives at most one result and m_tready stays high;
// a failure final response gives two results and fills both entries of the result register.
// Reset (aresetn low at a clock edge) clears the transaction and loads register defaults;
// no clearing pass. A stalled result output holds the input register, then s_tready.
`default_nettype none

module sip_client_invite_transaction #(
    parameter int TIMER_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] status_code
    input  wire logic [2:0]  s_tuser,   // [2:0] kind
    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] copy_credentials, [10:1] reported_code
    output logic [2:0]       m_tuser,   // [2:0] action
    output logic             m_tlast,
    // Configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    logic                             in_valid_reg, in_valid_next;
    logic [2:0]                       kind_reg;
    logic [9:0]                       code_reg;
    logic [sict_pkg::CFG_BITS-1:0]    base_reg;
    logic [sict_pkg::CFG_BITS-1:0]    overall_reg;
    logic [sict_pkg::CFG_BITS-1:0]    completed_reg;
    logic                             s_accept;
    logic                             space;
    logic                             fire;
    sict_pkg::sict_pair_t             pair;

    assign cfg_ready = 1'b1;

    // Take a new request when none is held or the held one is processed this cycle
    assign s_tready      = !in_valid_reg || space;
    assign s_accept      = s_tvalid && s_tready;
    assign fire          = in_valid_reg && space;
    assign in_valid_next = s_accept || (in_valid_reg && !fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            base_reg      <= 24'd500;
            overall_reg   <= 24'd32000;
            completed_reg <= 24'd32000;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sict_pkg::CFG_RETRANSMIT_BASE: base_reg      <= cfg_data;
                    sict_pkg::CFG_OVERALL_TIMEOUT: overall_reg   <= cfg_data;
                    sict_pkg::CFG_COMPLETED_WAIT:  completed_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (s_accept) begin
            kind_reg <= s_tuser;
            code_reg <= s_tdata[9:0];
        end
    end

    sict_txn #(
        .TIMER_BITS (TIMER_BITS)
    ) u_txn (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .fire                  (fire),
        .kind                  (kind_reg),
        .status_code           (code_reg),
        .retransmit_base_ticks (base_reg),
        .overall_timeout_ticks (overall_reg),
        .completed_wait_ticks  (completed_reg),
        .results               (pair)
    );

    sict_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .pair     (pair),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the SIP client INVITE transaction block.
`default_nettype none

module tb;

    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          SETTLE_TICKS = 8;       // room for results still in flight, including a double result
    localparam logic [23:0] TIMER_MAX    = 24'hFFFFFF;
    // Kind codes the block does not recognise
    localparam logic [2:0]  KIND_UNUSED_LO = 3'd5;
    localparam logic [2:0]  KIND_UNUSED_HI = 3'd7;

    typedef enum logic [2:0] {
        CALL_NULL, CALL_CALLING, CALL_PROCEEDING, CALL_COMPLETED, CALL_TERMINATED
    } call_phase_t;

    typedef struct {
        logic [2:0] action;
        logic       copy_credentials;
        logic [9:0] reported_code;
        logic       last;
    } call_action_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [15:0] m_tdata;
    wire logic [2:0]  m_tuser;
    wire logic        m_tlast;
    wire logic        cfg_ready;

    sip_client_invite_transaction dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow of the transaction state and registers
    call_phase_t  call_phase    = CALL_NULL;
    logic [23:0]  timer_a_left  = '0;
    logic [23:0]  timer_a_step  = '0;
    logic [23:0]  timer_b_left  = '0;
    logic [23:0]  timer_d_left  = '0;
    logic         ack_creds     = 1'b0;
    logic [23:0]  t1_ticks      = 24'd500;
    logic [23:0]  timeout_ticks = 24'd32000;
    logic [23:0]  wait_ticks    = 24'd32000;

    call_action_t pending_actions[$];
    int errors          = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int cycle_count     = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;

    // A zero register value still arms the timer for one tick
    function automatic logic [23:0] load_ticks(logic [23:0] v);
        return (v == '0) ? 24'd1 : v;
    endfunction

    // Load timer A and double the next interval, pinning it at full scale
    function automatic void arm_timer_a();
        timer_a_left = load_ticks(timer_a_step);
        timer_a_step = (timer_a_step > TIMER_MAX / 2) ? TIMER_MAX : timer_a_step << 1;
    endfunction

    function automatic call_action_t make_action(logic [2:0] act, logic creds,
                                                 logic [9:0] code);
        call_action_t r;
        r.action           = act;
        r.copy_credentials = creds;
        r.reported_code    = code;
        r.last             = 1'b0;
        return r;
    endfunction

    // Advance the shadow transaction by one request and queue the actions it yields
    function automatic void predict_call_actions(logic [2:0] kind, logic [9:0] code);
        call_action_t acts[$];
        logic success;
        logic fire_a;
        logic fire_b;
        success = (code >= sict_pkg::R_SUCCESS_LOW) && (code <= sict_pkg::R_SUCCESS_HIGH);
        fire_a  = 1'b0;
        fire_b  = 1'b0;
        case (kind)
            sict_pkg::KIND_START: begin
                if (call_phase == CALL_NULL || call_phase == CALL_TERMINATED) begin
                    timer_a_step = load_ticks(t1_ticks);
                    arm_timer_a();
                    timer_b_left = load_ticks(timeout_ticks);
                    timer_d_left = '0;
                    ack_creds    = 1'b0;
                    call_phase   = CALL_CALLING;
                    acts.insert(acts.size(), make_action(sict_pkg::ACT_SEND_REQ, 1'b0, '0));
                end
            end
            sict_pkg::KIND_PROVISIONAL: begin
                if (call_phase == CALL_CALLING || call_phase == CALL_PROCEEDING) begin
                    timer_a_left = '0;
                    timer_b_left = '0;
                    call_phase   = CALL_PROCEEDING;
                    acts.insert(acts.size(), make_action(sict_pkg::ACT_PROV, 1'b0, code));
                end
            end
            sict_pkg::KIND_FINAL: begin
                if (call_phase == CALL_CALLING || call_phase == CALL_PROCEEDING) begin
                    timer_a_left = '0;
                    timer_b_left = '0;
                    if (success) begin
                        call_phase = CALL_TERMINATED;
                    end else begin
                        ack_creds = (code != sict_pkg::STATUS_UNAUTHORIZED) &&
                                    (code != sict_pkg::STATUS_PROXY_AUTH);
                        acts.insert(acts.size(),
                                    make_action(sict_pkg::ACT_SEND_ACK, ack_creds, code));
                        timer_d_left = load_ticks(wait_ticks);
                        call_phase   = CALL_COMPLETED;
                    end
                    acts.insert(acts.size(), make_action(sict_pkg::ACT_FINAL, 1'b0, code));
                end else if (call_phase == CALL_COMPLETED && !success) begin
                    acts.insert(acts.size(),
                                make_action(sict_pkg::ACT_RESEND_ACK, ack_creds, code));
                end
            end
            sict_pkg::KIND_TICK: begin
                if (call_phase == CALL_CALLING) begin
                    if (timer_a_left != '0) begin
                        timer_a_left--;
                        fire_a = (timer_a_left == '0);
                    end
                    if (timer_b_left != '0) begin
                        timer_b_left--;
                        fire_b = (timer_b_left == '0);
                    end
                    // Timer B takes precedence when both run out together
                    if (fire_b) begin
                        timer_a_left = '0;
                        call_phase   = CALL_TERMINATED;
                        acts.insert(acts.size(), make_action(sict_pkg::ACT_TIMEOUT, 1'b0,
                                                             sict_pkg::STATUS_REQUEST_TIMEOUT));
                    end else if (fire_a) begin
                        arm_timer_a();
                        acts.insert(acts.size(),
                                    make_action(sict_pkg::ACT_SEND_REQ, 1'b0, '0));
                    end
                end else if (call_phase == CALL_COMPLETED && timer_d_left != '0) begin
                    timer_d_left--;
                    if (timer_d_left == '0) call_phase = CALL_TERMINATED;
                end
            end
            sict_pkg::KIND_ABORT: begin
                if (call_phase == CALL_PROCEEDING) begin
                    call_phase = CALL_TERMINATED;
                    acts.insert(acts.size(), make_action(sict_pkg::ACT_ABORTED, 1'b0,
                                                         sict_pkg::STATUS_REQUEST_TIMEOUT));
                end
            end
            default: ;
        endcase
        if (acts.size() > 0) acts[acts.size() - 1].last = 1'b1;
        foreach (acts[i]) pending_actions.insert(pending_actions.size(), acts[i]);
    endfunction

    // Offer one request, idling cycle by cycle at the sender's rate, and predict on acceptance
    task automatic send_request(logic [2:0] kind, logic [9:0] code);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, code};
        do @(posedge aclk); while (!s_tready);
        predict_call_actions(kind, code);
        requests_sent++;
    endtask

    // Hold the sender, then wait for every pending action plus the block's latency
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_actions.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sict_pkg::CFG_RETRANSMIT_BASE: t1_ticks      = value;
            sict_pkg::CFG_OVERALL_TIMEOUT: timeout_ticks = value;
            sict_pkg::CFG_COMPLETED_WAIT:  wait_ticks    = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_timers(logic [23:0] t1, logic [23:0] tb_ticks, logic [23:0] td);
        settle();
        write_reg(sict_pkg::CFG_RETRANSMIT_BASE, t1);
        write_reg(sict_pkg::CFG_OVERALL_TIMEOUT, tb_ticks);
        write_reg(sict_pkg::CFG_COMPLETED_WAIT, td);
    endtask

    // Mostly short timers so expiries happen often; zero and full scale now and then
    function automatic logic [23:0] random_ticks(int hi);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) return '0;
        if (pick == 1) return TIMER_MAX;
        return 24'($urandom_range(1, hi));
    endfunction

    function automatic logic [9:0] random_code();
        case ($urandom_range(0, 5))
            0: return 10'($urandom_range(100, 199));
            1: return 10'($urandom_range(200, 299));
            2: return 10'($urandom_range(300, 699));
            3: return $urandom_range(0, 1) ? sict_pkg::STATUS_UNAUTHORIZED :
                                             sict_pkg::STATUS_PROXY_AUTH;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Responses arriving outside a call, unknown kinds, and a first call on
    // the reset timer values
    task automatic test_defaults_and_ignored();
        send_request(sict_pkg::KIND_TICK, '0);
        send_request(sict_pkg::KIND_FINAL, 10'd486);
        send_request(sict_pkg::KIND_ABORT, '0);
        send_request(KIND_UNUSED_HI, 10'd1023);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_PROVISIONAL, 10'd100);
        send_request(sict_pkg::KIND_ABORT, '0);
        send_request(sict_pkg::KIND_PROVISIONAL, 10'd180);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_FINAL, sict_pkg::R_SUCCESS_HIGH);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_FINAL, sict_pkg::STATUS_UNAUTHORIZED);
        send_request(sict_pkg::KIND_FINAL, sict_pkg::STATUS_PROXY_AUTH);
        send_request(sict_pkg::KIND_FINAL, sict_pkg::R_SUCCESS_LOW);
        send_request(sict_pkg::KIND_PROVISIONAL, 10'd183);
        send_request(sict_pkg::KIND_ABORT, '0);
        send_request(sict_pkg::KIND_FINAL, 10'd1023);
    endtask

    // Zero registers, simultaneous expiry of A and B, and full-scale timers
    task automatic test_timer_extremes();
        set_timers('0, '0, '0);
        send_request(KIND_UNUSED_LO, '0);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_TICK, '0);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_FINAL, '0);
        send_request(sict_pkg::KIND_TICK, '0);
        set_timers(24'd2, 24'd6, TIMER_MAX);
        send_request(sict_pkg::KIND_START, '0);
        repeat (6) send_request(sict_pkg::KIND_TICK, '0);
        set_timers(TIMER_MAX, TIMER_MAX, TIMER_MAX);
        send_request(sict_pkg::KIND_START, '0);
        send_request(sict_pkg::KIND_TICK, '0);
        send_request(sict_pkg::KIND_FINAL, 10'd699);
        send_request(sict_pkg::KIND_TICK, '0);
    endtask

    // One call with random content: start, ticks, perhaps provisionals, then an ending
    task automatic run_random_call();
        send_request(sict_pkg::KIND_START, 10'($urandom_range(0, 1023)));
        repeat ($urandom_range(0, 8))
            send_request(sict_pkg::KIND_TICK, 10'($urandom_range(0, 1023)));
        if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 2)) send_request(sict_pkg::KIND_PROVISIONAL, random_code());
            repeat ($urandom_range(0, 3)) send_request(sict_pkg::KIND_TICK, '0);
        end
        case ($urandom_range(0, 9))
            0, 1: send_request(sict_pkg::KIND_ABORT, 10'($urandom_range(0, 1023)));
            2, 3, 4, 5, 6, 7: begin
                send_request(sict_pkg::KIND_FINAL, random_code());
                repeat ($urandom_range(0, 2)) send_request(sict_pkg::KIND_FINAL, random_code());
                repeat ($urandom_range(0, 12)) send_request(sict_pkg::KIND_TICK, '0);
            end
            default: repeat ($urandom_range(0, 30)) send_request(sict_pkg::KIND_TICK, '0);
        endcase
    endtask

    // Mostly well-formed calls, some noise; drain and retune timers every so often
    task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
        int stop_at;
        int next_retune;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        stop_at       = requests_sent + count;
        next_retune   = requests_sent;
        while (requests_sent < stop_at) begin
            if (requests_sent >= next_retune) begin
                set_timers(random_ticks(10), random_ticks(60), random_ticks(12));
                next_retune = requests_sent + 140;
            end
            if ($urandom_range(0, 99) < 15)
                send_request(3'($urandom_range(0, 7)), 10'($urandom_range(0, 1023)));
            else
                run_random_call();
        end
    endtask

    // Receiver stalls at its current rate, decided afresh each cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        call_action_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (pending_actions.size() == 0) begin
                $error("unexpected result: action %0d code %0d", m_tuser, m_tdata[10:1]);
                errors++;
            end else begin
                want = pending_actions.pop_front();
                if (m_tuser !== want.action) begin
                    $error("action: expected %0d, got %0d", want.action, m_tuser);
                    errors++;
                end
                if (m_tdata[0] !== want.copy_credentials) begin
                    $error("copy_credentials: expected %0d, got %0d",
                           want.copy_credentials, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[10:1] !== want.reported_code) begin
                    $error("reported_code: expected %0d, got %0d",
                           want.reported_code, m_tdata[10:1]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending_actions.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_defaults_and_ignored();
        test_timer_extremes();
        test_random_traffic(14, 68, 400);
        test_random_traffic(68, 14, 400);
        test_random_traffic(0, 0, 400);
        settle();
        $display("Sent %0d requests and checked %0d results over three stall profiles,",
                 requests_sent, results_checked);
        $display("with timer settings from zero to full scale; %0d mismatches.", errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
